>>> rtl/lsp2p_pkg.sv
`default_nettype none
package lsp2p_pkg;

  localparam int IMAGE_SIZE_DEF = 500;

  localparam logic [1:0] REG_RANGE_MIN   = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX   = 2'd1;
  localparam logic [1:0] REG_START_ANGLE = 2'd2;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd3;

  localparam logic [15:0] RANGE_MIN_RST   = 16'd0;
  localparam logic [15:0] RANGE_MAX_RST   = 16'd12000;
  localparam logic [15:0] START_ANGLE_RST = 16'd0;
  localparam logic [15:0] ANGLE_STEP_RST  = 16'd182;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [11:0] SIN_C3       = 12'd2320;
  localparam logic [14:0] SIN_C2       = 15'd21024;
  localparam logic [15:0] SIN_C1       = 16'd51472;
  localparam logic [14:0] TRIG_MAX     = 15'h7FFF;

  localparam int PIX_W = 9;

  typedef struct packed {
    logic       ok;
    logic [1:0] neg;
  } flags_t;

endpackage
`default_nettype wire

>>> rtl/lsp2p_qsine.sv
`default_nettype none
// Five-stage polynomial sine for two lanes: lane 0 is the cosine, lane 1 the sine.
module lsp2p_qsine import lsp2p_pkg::*; #(
  parameter int SW = 17
) (
  input  wire logic          clk,
  input  wire logic [4:0]    en,
  input  wire logic [15:0]   ang,
  input  wire logic [SW-1:0] side_i,
  output logic [14:0]        mag [2],
  output logic [1:0]         neg,
  output logic [SW-1:0]      side_o
);

  logic [15:0] a [2];
  logic [14:0] z1 [2], z2 [2], z3 [2], z4 [2];
  logic [14:0] sq2 [2], sq3 [2];
  logic [14:0] u3 [2];
  logic [15:0] v4 [2];
  logic [1:0]  n1, n2, n3, n4;
  logic [SW-1:0] sd1, sd2, sd3, sd4;
  logic [29:0] m2 [2];
  logic [26:0] m3 [2];
  logic [29:0] m4 [2];
  logic [30:0] m5 [2];

  assign a[0] = ang + QUARTER_TURN;
  assign a[1] = ang;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      m2[l] = 30'(z1[l]) * 30'(z1[l]);
      m3[l] = 27'(sq2[l]) * 27'(SIN_C3);
      m4[l] = 30'(sq3[l]) * 30'(u3[l]);
      m5[l] = 31'(z4[l]) * 31'(v4[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en[0]) begin
        z1[l] <= a[l][14] ? 15'(15'd16384 - 15'(a[l][13:0])) : {1'b0, a[l][13:0]};
        n1[l] <= a[l][15];
      end
      if (en[1]) begin
        z2[l]  <= z1[l];
        sq2[l] <= m2[l][28:14];
        n2[l]  <= n1[l];
      end
      if (en[2]) begin
        z3[l]  <= z2[l];
        sq3[l] <= sq2[l];
        u3[l]  <= 15'(SIN_C2 - 15'(m3[l][26:14]));
        n3[l]  <= n2[l];
      end
      if (en[3]) begin
        z4[l] <= z3[l];
        v4[l] <= 16'(SIN_C1 - m4[l][29:14]);
        n4[l] <= n3[l];
      end
      if (en[4]) begin
        mag[l] <= (m5[l][30:14] > 17'(TRIG_MAX)) ? TRIG_MAX : m5[l][28:14];
        neg[l] <= n4[l];
      end
    end
    if (en[0]) sd1 <= side_i;
    if (en[1]) sd2 <= sd1;
    if (en[2]) sd3 <= sd2;
    if (en[3]) sd4 <= sd3;
    if (en[4]) side_o <= sd4;
  end

endmodule
`default_nettype wire

>>> rtl/lsp2p_div_cell.sv
`default_nettype none
// One restoring division step for both lanes.
module lsp2p_div_cell import lsp2p_pkg::*; #(
  parameter int QW = 9
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [15:0]   d,
  input  wire logic [15:0]   rem_i [2],
  input  wire logic [QW-1:0] low_i [2],
  input  wire logic [QW-1:0] q_i [2],
  input  wire flags_t        flg_i,
  output logic [15:0]        rem_o [2],
  output logic [QW-1:0]      low_o [2],
  output logic [QW-1:0]      q_o [2],
  output flags_t             flg_o
);

  logic [16:0] t [2];
  logic        ge [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l]  = {rem_i[l], low_i[l][QW-1]};
      ge[l] = t[l] >= {1'b0, d};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem_o[l] <= ge[l] ? 16'(t[l] - {1'b0, d}) : t[l][15:0];
        low_o[l] <= {low_i[l][QW-2:0], 1'b0};
        q_o[l]   <= {q_i[l][QW-2:0], ge[l]};
      end
      flg_o <= flg_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/laser_scan_polar_to_pixel_core.sv
`default_nettype none
// Projects one lidar range sample per cycle into an IMAGE_SIZE square image. Each word passes
// a fixed pipeline of 9 + clog2(IMAGE_SIZE) stages (18 at the default size): the beam angle,
// five stages of sine polynomial, two product stages, one restoring-division cell per
// quotient bit and the output register. Every stage moves on when its successor has room,
// so a new word is taken each cycle unless the whole pipeline is full and the output is held.
module laser_scan_polar_to_pixel_core import lsp2p_pkg::*; #(
  parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // range_mm, sample_index
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // pixel_x, pixel_y
  output logic             m_tuser,   // hit
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int ISW = $clog2(IMAGE_SIZE + 1);
  localparam int QW  = $clog2(IMAGE_SIZE);
  localparam int PW  = 31;
  localparam int NW  = PW + ISW - 16;
  localparam int NST = 9 + QW;
  localparam int XW  = ISW + 2;
  localparam logic [ISW-1:0] IS_V = ISW'(IMAGE_SIZE);
  localparam logic [XW-1:0]  HALF = XW'(IMAGE_SIZE / 2);

  logic [15:0] range_min_mm, range_max_mm, start_angle, angle_step;
  logic [NST-1:0] v, en;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min_mm <= RANGE_MIN_RST;
      range_max_mm <= RANGE_MAX_RST;
      start_angle  <= START_ANGLE_RST;
      angle_step   <= ANGLE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN:   range_min_mm <= cfg_data;
        REG_RANGE_MAX:   range_max_mm <= cfg_data;
        REG_START_ANGLE: start_angle  <= cfg_data;
        REG_ANGLE_STEP:  angle_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NST-1] = !v[NST-1] || m_tready;
    for (int i = NST - 2; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NST-1];

  logic [15:0] in_range;
  logic [27:0] ang_prod;
  logic [15:0] ang0, range0;
  logic        ok0;

  assign in_range = s_tdata[15:0];
  assign ang_prod = 28'(s_tdata[27:16]) * 28'(angle_step);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ang0   <= start_angle + ang_prod[15:0];
      range0 <= in_range;
      ok0    <= (in_range > range_min_mm) && (in_range < range_max_mm);
    end
  end

  logic [14:0] mag [2];
  logic [1:0]  sgn;
  logic [16:0] side;

  lsp2p_qsine #(.SW(17)) u_sine (
    .clk    (clk),
    .en     (en[5:1]),
    .ang    (ang0),
    .side_i ({ok0, range0}),
    .mag    (mag),
    .neg    (sgn),
    .side_o (side)
  );

  logic [PW-1:0] pr [2];
  logic [PW+ISW-1:0] full [2];
  logic [NW-1:0] nn [2];
  flags_t f6, f7;

  always_comb begin
    for (int l = 0; l < 2; l++) full[l] = (PW+ISW)'(pr[l]) * (PW+ISW)'(IS_V);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int l = 0; l < 2; l++) pr[l] <= PW'(side[15:0]) * PW'(mag[l]);
      f6 <= '{ok: side[16], neg: sgn};
    end
    if (en[7]) begin
      for (int l = 0; l < 2; l++) nn[l] <= full[l][PW+ISW-1:16];
      f7 <= f6;
    end
  end

  logic [15:0]   rem_c [QW+1][2];
  logic [QW-1:0] low_c [QW+1][2];
  logic [QW-1:0] q_c   [QW+1][2];
  flags_t        flg_c [QW+1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_c[0][l] = 16'(nn[l] >> QW);
      low_c[0][l] = nn[l][QW-1:0];
      q_c[0][l]   = '0;
    end
    flg_c[0] = f7;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    lsp2p_div_cell #(.QW(QW)) u_cell (
      .clk   (clk),
      .en    (en[8+k]),
      .d     (range_max_mm),
      .rem_i (rem_c[k]),
      .low_i (low_c[k]),
      .q_i   (q_c[k]),
      .flg_i (flg_c[k]),
      .rem_o (rem_c[k+1]),
      .low_o (low_c[k+1]),
      .q_o   (q_c[k+1]),
      .flg_o (flg_c[k+1])
    );
  end

  logic signed [XW-1:0] pos [2];
  logic in_img [2];
  logic hit;
  flags_t fo;

  assign fo = flg_c[QW];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pos[l] = fo.neg[l] ? signed'(HALF - XW'(q_c[QW][l])) : signed'(HALF + XW'(q_c[QW][l]));
      in_img[l] = (pos[l] >= 0) && (pos[l] < signed'(XW'(IMAGE_SIZE)));
    end
    hit = fo.ok && in_img[0] && in_img[1];
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      m_tdata <= {6'b0, hit ? PIX_W'(pos[1]) : PIX_W'(0), hit ? PIX_W'(pos[0]) : PIX_W'(0)};
      m_tuser <= hit;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lsp2p_checker.sv
`default_nettype none
module lsp2p_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word present straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("coordinates not zero on a miss");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[8:0] != 9'd0 && m_tdata[17:9] != 9'd0)
    else $error("hit coordinate on the image border");

endmodule

bind laser_scan_polar_to_pixel_core lsp2p_checker u_lsp2p_checker (.*);
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
  import lsp2p_pkg::*;

  localparam int IMG = 500;

  typedef struct packed {
    logic [8:0] px;
    logic [8:0] py;
    logic       hit;
  } pixel_t;

  typedef struct {
    logic [15:0] range_mm;
    logic [11:0] index;
    logic        known;
    pixel_t      pix;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_RANGE_MIN;
  logic [15:0] cfg_data = '0;

  logic [15:0] min_mm, max_mm, start_ang, step_ang;
  pixel_t pixel_q[$];
  int errors = 0;
  bit calm = 1'b0;
  int sink_idle = 0;

  laser_scan_polar_to_pixel_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

  function automatic longint quarter_wave(input longint r);
    longint z2, u, v, s;
    z2 = (r * r) >>> 14;
    u = 21024 - ((z2 * 2320) >>> 14);
    v = 51472 - ((z2 * u) >>> 14);
    s = (r * v) >>> 14;
    if (s > 32767) s = 32767;
    return s;
  endfunction

  function automatic longint sine_of(input logic [15:0] a);
    longint s;
    s = a[14] ? quarter_wave(16384 - longint'(a[13:0])) : quarter_wave(longint'(a[13:0]));
    return a[15] ? -s : s;
  endfunction

  function automatic longint offset_of(input longint rng, input longint trig);
    longint mag, q, den;
    den = longint'(max_mm) * 65536;
    mag = trig < 0 ? -trig : trig;
    q = (rng * mag * IMG) / den;
    return trig < 0 ? -q : q;
  endfunction

  function automatic pixel_t project_sample(input logic [15:0] rng, input logic [11:0] idx);
    pixel_t p;
    logic [15:0] ang;
    longint x, y;
    p = '0;
    if (rng > min_mm && rng < max_mm) begin
      ang = start_ang + 16'(idx * step_ang);
      x = offset_of(rng, sine_of(ang + 16'd16384)) + IMG / 2;
      y = offset_of(rng, sine_of(ang)) + IMG / 2;
      if (x >= 0 && x < IMG && y >= 0 && y < IMG) begin
        p.px = 9'(x);
        p.py = 9'(y);
        p.hit = 1'b1;
      end
    end
    return p;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RANGE_MIN:   min_mm = val;
      REG_RANGE_MAX:   max_mm = val;
      REG_START_ANGLE: start_ang = val;
      REG_ANGLE_STEP:  step_ang = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic send_sample(input logic [15:0] rng, input logic [11:0] idx,
                             input bit known, input pixel_t pix);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    pixel_q = {pixel_q, (known ? pix : project_sample(rng, idx))};
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, idx, rng};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      logic [15:0] r;
      case ($urandom_range(0, 3))
        0: r = 16'($urandom);
        1: r = 16'($urandom_range(0, 3)) + (min_mm > 1 ? min_mm - 16'd1 : 16'd0);
        2: r = max_mm - 16'($urandom_range(0, 2));
        default: r = 16'($urandom_range(0, max_mm));
      endcase
      send_sample(r, 12'($urandom), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    drain();
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{px: m_tdata[8:0], py: m_tdata[17:9], hit: m_tuser};
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $realtime, got);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.px !== want.px) begin
          $display("%0t: pixel_x expected %0d actual %0d", $realtime, want.px, got.px);
          errors++;
        end
        if (got.py !== want.py) begin
          $display("%0t: pixel_y expected %0d actual %0d", $realtime, want.py, got.py);
          errors++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $realtime, want.hit, got.hit);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      m_tready <= !rst;
    end else if (sink_idle > 0) begin
      sink_idle--;
      m_tready <= (sink_idle == 0);
    end else if ($urandom_range(0, 7) == 0) begin
      sink_idle = $urandom_range(1, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    row_t rows[$];
    int waited;
    min_mm = RANGE_MIN_RST;
    max_mm = RANGE_MAX_RST;
    start_ang = START_ANGLE_RST;
    step_ang = ANGLE_STEP_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero range, range at both bounds, full turn of quadrants and index extremes.
    rows = {rows, row_t'{16'd0, 12'd0, 1'b1, pixel_t'('0)}};
    rows = {rows, row_t'{16'd12000, 12'd0, 1'b1, pixel_t'('0)}};
    rows = {rows, row_t'{16'hFFFF, 12'hFFF, 1'b1, pixel_t'('0)}};
    rows = {rows, row_t'{16'd1, 12'd0, 1'b1, pixel_t'{9'd250, 9'd250, 1'b1}}};
    rows = {rows, row_t'{16'd11999, 12'd0, 1'b1, pixel_t'{9'd499, 9'd250, 1'b1}}};
    rows = {rows, row_t'{16'd11999, 12'hFFF, 1'b0, pixel_t'('0)}};
    for (int k = 0; k < 12; k++)
      rows = {rows, row_t'{16'(11000 - k * 700), 12'(k * 45), 1'b0, pixel_t'('0)}};
    foreach (rows[i]) send_sample(rows[i].range_mm, rows[i].index, rows[i].known, rows[i].pix);
    s_tvalid <= 1'b0;
    drain();
    random_phase(250);

    // Angle wrap with the extreme step values, empty range windows and a random setup.
    write_reg(REG_RANGE_MIN, 16'd500);
    write_reg(REG_START_ANGLE, 16'h8000);
    write_reg(REG_ANGLE_STEP, 16'h7FFF);
    random_phase(250);
    write_reg(REG_ANGLE_STEP, 16'h8000);
    write_reg(REG_START_ANGLE, 16'h7FFF);
    write_reg(REG_RANGE_MAX, 16'hFFFF);
    write_reg(REG_RANGE_MIN, 16'd0);
    random_phase(250);
    write_reg(REG_RANGE_MAX, 16'd1);
    random_phase(100);
    write_reg(REG_RANGE_MAX, 16'd0);
    random_phase(100);
    write_reg(REG_RANGE_MIN, 16'hFFFF);
    write_reg(REG_RANGE_MAX, 16'd40);
    random_phase(100);
    write_reg(REG_RANGE_MIN, 16'd0);
    write_reg(REG_RANGE_MAX, 16'd5000);
    write_reg(REG_START_ANGLE, 16'($urandom));
    write_reg(REG_ANGLE_STEP, 16'($urandom));
    random_phase(300);
    calm = 1'b1;
    random_phase(200);

    waited = 0;
    while (pixel_q.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (30) @(negedge clk);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/lsp2p_pkg.sv
rtl/lsp2p_qsine.sv
rtl/lsp2p_div_cell.sv
rtl/laser_scan_polar_to_pixel_core.sv
rtl/lsp2p_checker.sv
sim/testbench.sv
